// ----- src/spd_pkg.sv -----
package spd_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int WORD_W      = 32;

    typedef enum logic [1:0] {
        ACT_PAT  = 2'd0,
        ACT_DATA = 2'd1,
        ACT_END  = 2'd2
    } t_action;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_CMP_RD   = 7'b0000010,
        ST_CMP      = 7'b0000100,
        ST_EMIT_RD  = 7'b0001000,
        ST_EMIT     = 7'b0010000,
        ST_FLUSH_RD = 7'b0100000,
        ST_FLUSH    = 7'b1000000
    } t_state;

endpackage

// ----- src/stream_pattern_deleter.sv -----
// Channel  | valid    | stall    | payload
// ---------+----------+----------+------------------------------------------
// request  | i_valid  | o_stall  | i_action, i_word
// result   | o_valid  | i_stall  | o_has_word, o_out_word, o_last
//
// A pattern word is stored unless the pattern is full. A data word is compared
// with the pattern word by word, each comparison and each released word first
// reading the registered pattern memory; with an empty pattern it is released
// without comparison. An end request releases the pending words, the last one marked last, or one wordless last result.
// Synchronous active-low reset; pattern and pending count read as empty after it.
// Requests are taken only in the idle state; a held result does not block them.
module stream_pattern_deleter
    import spd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_action,
    input  logic signed [WORD_W-1:0] i_word,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_has_word,
    output logic signed [WORD_W-1:0] o_out_word,
    output logic                     o_last
);

    // pattern memory, two registered read ports
    logic [WORD_W-1:0] r_pat [MAX_PATTERN];
    logic [WORD_W-1:0] r_qa;
    logic [WORD_W-1:0] r_qb;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_s, n_s;
    logic [IDX_W-1:0]  r_j, n_j;
    logic [WORD_W-1:0] r_w, n_w;

    logic              r_ov;
    logic              r_o_has;
    logic [WORD_W-1:0] r_o_word;
    logic              r_o_last;

    logic              pat_we;
    logic [IDX_W-1:0]  addr_a;
    logic [IDX_W-1:0]  addr_b;
    logic [CNT_W-1:0]  k;
    logic [CNT_W-1:0]  c;
    logic [CNT_W-1:0]  s_inc;
    logic [CNT_W-1:0]  remain;
    logic [WORD_W-1:0] cur;
    logic              out_free;
    logic              ld;
    logic              ld_has;
    logic [WORD_W-1:0] ld_word;
    logic              ld_last;

    assign k        = r_s + CNT_W'(r_j);
    assign c        = r_n - CNT_W'(1);
    assign s_inc    = r_s + CNT_W'(1);
    assign remain   = r_n - r_s;
    assign cur      = (k == c) ? r_w : r_qb;
    assign addr_a   = r_j;
    assign addr_b   = k[IDX_W-1:0];
    assign out_free = !r_ov || !i_stall;

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_s     = r_s;
        n_j     = r_j;
        n_w     = r_w;
        pat_we  = 1'b0;
        ld      = 1'b0;
        ld_has  = 1'b0;
        ld_word = '0;
        ld_last = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_action)
                        ACT_PAT: begin
                            if (r_len < CNT_W'(MAX_PATTERN)) begin
                                pat_we = 1'b1;
                                n_len  = r_len + CNT_W'(1);
                            end
                        end
                        ACT_DATA: begin
                            n_w = i_word;
                            n_s = '0;
                            if (r_len == '0) begin
                                n_n     = CNT_W'(1);
                                n_j     = '0;
                                n_state = ST_EMIT;
                            end else begin
                                n_n     = r_cnt + CNT_W'(1);
                                n_j     = r_cnt[IDX_W-1:0];
                                n_state = ST_CMP_RD;
                            end
                        end
                        ACT_END: begin
                            n_n     = r_cnt;
                            n_s     = '0;
                            n_j     = '0;
                            n_cnt   = '0;
                            n_len   = '0;
                            n_state = ST_FLUSH_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CMP_RD: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (cur == r_qa) begin
                    if (k == c) begin
                        n_cnt   = (remain == r_len) ? '0 : remain;
                        n_state = ST_IDLE;
                    end else begin
                        n_j     = r_j + IDX_W'(1);
                        n_state = ST_CMP_RD;
                    end
                end else begin
                    n_j     = '0;
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    ld      = 1'b1;
                    ld_has  = 1'b1;
                    ld_word = cur;
                    n_s     = s_inc;
                    n_j     = '0;
                    if (s_inc == r_n) begin
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_CMP_RD;
                    end
                end
            end
            ST_FLUSH_RD: begin
                n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (out_free) begin
                    ld = 1'b1;
                    if (r_n == '0) begin
                        ld_last = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        ld_has  = 1'b1;
                        ld_word = r_qb;
                        ld_last = (s_inc == r_n);
                        n_s     = s_inc;
                        n_state = (s_inc == r_n) ? ST_IDLE : ST_FLUSH_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            r_pat[r_len[IDX_W-1:0]] <= i_word;
        end
        r_qa <= r_pat[addr_a];
        r_qb <= r_pat[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            if (ld) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;
        r_s <= n_s;
        r_j <= n_j;
        r_w <= n_w;
        if (ld) begin
            r_o_has  <= ld_has;
            r_o_word <= ld_word;
            r_o_last <= ld_last;
        end
    end

    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_ov;
    assign o_has_word = r_o_has;
    assign o_out_word = r_o_word;
    assign o_last     = r_o_last;

    // in idle, pending words are a proper prefix of the pattern: count below its length
    a_cnt_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_cnt == '0 || r_cnt < r_len))
        else $error("pending count not below pattern length");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CNT_W'(MAX_PATTERN))
        else $error("pattern length overflow");

    a_cmp_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (k <= c))
        else $error("comparison index past candidate end");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_action == ACT_END) |=> (r_len == '0 && r_cnt == '0))
        else $error("end request did not clear pattern");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld |-> out_free)
        else $error("result register loaded while held");

endmodule
